FILE: rtl/bfpm_pkg.sv
// ----------------------------------------------------------------------------
// bfpm_pkg
// Shared types, constants and helpers of the Bloom filter probe engine.
// ----------------------------------------------------------------------------
package bfpm_pkg;

   // Filter store geometry
   localparam int FILTER_BYTES = 1048576;
   localparam int ADDR_W       = $clog2(FILTER_BYTES);
   localparam int MAX_PROBES   = 32;

   // Field and register widths
   localparam int HASH_W       = 32;
   localparam int KEY_WORDS    = 5;
   localparam int WORD_SEL_W   = 3;
   localparam int BYTE_ADDR_W  = 20;
   localparam int BYTE_VAL_W   = 8;
   localparam int NB_W         = 24;
   localparam int PC_W         = 6;
   localparam int CNT_W        = 6;
   localparam int REQ_FIELD_W  = BYTE_ADDR_W + BYTE_VAL_W + KEY_WORDS * HASH_W;
   localparam int REQ_DATA_W   = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = 8;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 24;

   // Field offsets inside req_tdata
   localparam int OFS_ADDR     = 0;
   localparam int OFS_VALUE    = OFS_ADDR + BYTE_ADDR_W;
   localparam int OFS_KEY      = OFS_VALUE + BYTE_VAL_W;

   // MurmurHash3 x86_32 constants
   localparam logic [HASH_W-1:0] MM_C1    = 32'hcc9e2d51;
   localparam logic [HASH_W-1:0] MM_C2    = 32'h1b873593;
   localparam logic [HASH_W-1:0] MM_ADD   = 32'he6546b64;
   localparam logic [HASH_W-1:0] MM_F1    = 32'h85ebca6b;
   localparam logic [HASH_W-1:0] MM_F2    = 32'hc2b2ae35;
   localparam logic [HASH_W-1:0] SEED_A   = 32'd42;
   localparam logic [HASH_W-1:0] SEED_MIX = 32'h5f3759df;
   localparam logic [HASH_W-1:0] KEY_LEN  = 32'd20;

   // Register reset values
   localparam logic [NB_W-1:0] NB_RESET = 24'd8388608;
   localparam logic [PC_W-1:0] PC_RESET = 6'd1;

   // Item kinds carried on req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PROBE = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_COUNT   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_PROBE_COUNT = 1'b1;

   // Hash selectors
   localparam logic SEL_HASH_A = 1'b0;
   localparam logic SEL_HASH_B = 1'b1;

   typedef struct packed {
      logic [NB_W-1:0] bit_count;
      logic [PC_W-1:0] probe_count;
   } cfg_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CAPTURE,
      DP_MEM_WRITE,
      DP_HASH_INIT,
      DP_KMUL1,
      DP_KMUL2,
      DP_HMIX,
      DP_FIN1,
      DP_FIN2,
      DP_FIN3,
      DP_DIV_LOAD,
      DP_DIV_STEP,
      DP_SAVE_RUN,
      DP_SAVE_STEP,
      DP_MEM_READ,
      DP_ADVANCE
   } dp_op_type;

   typedef struct packed {
      dp_op_type             op;
      logic [WORD_SEL_W-1:0] word_sel;
      logic                  hash_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic bit_set;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_H_INIT,
      ST_K1,
      ST_K2,
      ST_HMIX,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_D_LOAD,
      ST_D_STEP,
      ST_D_SAVE,
      ST_RD,
      ST_TEST,
      ST_DONE
   } ctrl_state_type;

   function automatic logic [HASH_W-1:0] rotl32(input logic [HASH_W-1:0] x,
                                                 input int unsigned r);
      rotl32 = (x << r) | (x >> (HASH_W - r));
   endfunction

endpackage

FILE: rtl/bfpm_csr.sv
// ----------------------------------------------------------------------------
// bfpm_csr
// Configuration registers: filter bit count and probes per key.
// ----------------------------------------------------------------------------
module bfpm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bfpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfpm_pkg::CSR_DATA_W-1:0]  csr_data,
   output bfpm_pkg::cfg_type                cfg
);
   import bfpm_pkg::*;

   logic [NB_W-1:0] bit_count_ff;
   logic [PC_W-1:0] probe_count_ff;

   // always take a write transaction
   assign csr_ready = 1'b1;

   // update the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_count_ff   <= NB_RESET;
         probe_count_ff <= PC_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BIT_COUNT:   bit_count_ff   <= csr_data[NB_W-1:0];
            REG_PROBE_COUNT: probe_count_ff <= csr_data[PC_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.bit_count   = bit_count_ff;
   assign cfg.probe_count = probe_count_ff;

endmodule

FILE: rtl/bfpm_dpath.sv
// ----------------------------------------------------------------------------
// bfpm_dpath
// Datapath: item capture, filter byte store, shared hash multiplier,
// bit-serial remainder unit and probe index accumulator.
// ----------------------------------------------------------------------------
module bfpm_dpath (
   input  logic                             clock,
   input  bfpm_pkg::dp_cmd_type             cmd,
   input  logic [bfpm_pkg::REQ_FIELD_W-1:0] req_fields,
   input  logic [bfpm_pkg::NB_W-1:0]        bit_count,
   output bfpm_pkg::dp_status_type          status
);
   import bfpm_pkg::*;

   // captured item
   logic [HASH_W-1:0]      key_ff [KEY_WORDS];
   logic [ADDR_W-1:0]      wr_addr_ff;
   logic [BYTE_VAL_W-1:0]  wr_value_ff;

   // hash state
   logic [HASH_W-1:0]      k_ff, k_in;
   logic [HASH_W-1:0]      h_ff, h_in;
   logic [HASH_W-1:0]      hash_a_ff, hash_b_ff;

   // remainder unit
   logic [HASH_W-1:0]      dvd_ff;
   logic [NB_W-1:0]        rem_ff;
   logic [NB_W:0]          rem_sh;
   logic [NB_W-1:0]        rem_in;

   // probe index, kept reduced modulo the bit count
   logic [NB_W-1:0]        run_ff, step_ff;
   logic [NB_W:0]          run_sum;
   logic [NB_W-1:0]        run_in;

   // filter store
   logic [BYTE_VAL_W-1:0]  mem [FILTER_BYTES];
   logic [BYTE_VAL_W-1:0]  rd_data_ff;
   logic                   oob_ff;
   logic                   oob_in;

   // shared multiplier
   logic [HASH_W-1:0]      mul_x, mul_y, mul_p;
   logic [HASH_W-1:0]      mix_t, fin_t, seed;

   // capture the item fields
   always_ff @(posedge clock) begin
      if (cmd.op == DP_CAPTURE) begin
         wr_addr_ff  <= req_fields[OFS_ADDR +: ADDR_W];
         wr_value_ff <= req_fields[OFS_VALUE +: BYTE_VAL_W];
         for (int w = 0; w < KEY_WORDS; w++) begin
            key_ff[w] <= req_fields[OFS_KEY + w*HASH_W +: HASH_W];
         end
      end
   end

   // select multiplier operands and next hash values
   always_comb begin
      seed  = (cmd.hash_sel == SEL_HASH_B) ? (SEED_A ^ SEED_MIX) : SEED_A;
      mix_t = rotl32(h_ff ^ k_ff, 13);
      fin_t = h_ff ^ KEY_LEN;
      fin_t = fin_t ^ (fin_t >> 16);
      mul_x = '0;
      mul_y = '0;
      k_in  = k_ff;
      h_in  = h_ff;
      case (cmd.op)
         DP_HASH_INIT: h_in = seed;
         DP_KMUL1: begin
            mul_x = key_ff[cmd.word_sel];
            mul_y = MM_C1;
            k_in  = mul_p;
         end
         DP_KMUL2: begin
            mul_x = rotl32(k_ff, 15);
            mul_y = MM_C2;
            k_in  = mul_p;
         end
         DP_HMIX: h_in = mix_t + (mix_t << 2) + MM_ADD;
         DP_FIN1: begin
            mul_x = fin_t;
            mul_y = MM_F1;
            h_in  = mul_p;
         end
         DP_FIN2: begin
            mul_x = h_ff ^ (h_ff >> 13);
            mul_y = MM_F2;
            h_in  = mul_p;
         end
         default: ;
      endcase
   end

   assign mul_p = mul_x * mul_y;

   // hash registers
   always_ff @(posedge clock) begin
      k_ff <= k_in;
      h_ff <= h_in;
      if (cmd.op == DP_FIN3) begin
         if (cmd.hash_sel == SEL_HASH_B) begin
            hash_b_ff <= h_ff ^ (h_ff >> 16);
         end else begin
            hash_a_ff <= h_ff ^ (h_ff >> 16);
         end
      end
   end

   // one quotient bit per step, restoring
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[HASH_W-1]};
      rem_in = (rem_sh >= {1'b0, bit_count}) ? NB_W'(rem_sh - {1'b0, bit_count})
                                             : rem_sh[NB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_DIV_LOAD) begin
         dvd_ff <= (cmd.hash_sel == SEL_HASH_B) ? hash_b_ff : hash_a_ff;
         rem_ff <= '0;
      end else if (cmd.op == DP_DIV_STEP) begin
         dvd_ff <= dvd_ff << 1;
         rem_ff <= rem_in;
      end
   end

   // advance the probe index by the second hash, wrapped at the bit count
   always_comb begin
      run_sum = {1'b0, run_ff} + {1'b0, step_ff};
      run_in  = (run_sum >= {1'b0, bit_count}) ? NB_W'(run_sum - {1'b0, bit_count})
                                               : run_sum[NB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_SAVE_RUN) begin
         run_ff <= rem_ff;
      end else if (cmd.op == DP_ADVANCE) begin
         run_ff <= run_in;
      end
      if (cmd.op == DP_SAVE_STEP) begin
         step_ff <= rem_ff;
      end
   end

   // filter byte store, registered read
   assign oob_in = run_ff[NB_W-1:3] >= (NB_W-3)'(FILTER_BYTES);

   always_ff @(posedge clock) begin
      if (cmd.op == DP_MEM_WRITE) begin
         mem[wr_addr_ff] <= wr_value_ff;
      end
      if (cmd.op == DP_MEM_READ) begin
         rd_data_ff <= mem[run_ff[ADDR_W+2:3]];
         oob_ff     <= oob_in;
      end
   end

   assign status.bit_set = rd_data_ff[run_ff[2:0]] && !oob_ff;

endmodule

FILE: rtl/bfpm_ctrl.sv
// ----------------------------------------------------------------------------
// bfpm_ctrl
// Controller: sequences capture, both hashes, the two remainders and the
// bit tests of a probe, and holds the result register.
// ----------------------------------------------------------------------------
module bfpm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic                     req_op,
   input  bfpm_pkg::cfg_type        cfg,
   input  logic                     rsp_tready,
   output logic                     rsp_tvalid,
   output logic                     rsp_present,
   output bfpm_pkg::dp_cmd_type     cmd,
   input  bfpm_pkg::dp_status_type  status
);
   import bfpm_pkg::*;

   ctrl_state_type        state_ff, state_in;
   logic [WORD_SEL_W-1:0] word_ff, word_in;
   logic                  sel_ff, sel_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  present_ff, present_in;
   logic [PC_W-1:0]       probes;
   logic                  rsp_free;

   // clamp probes per key
   assign probes   = (cfg.probe_count > PC_W'(MAX_PROBES)) ? PC_W'(MAX_PROBES)
                                                           : cfg.probe_count;
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_ff      <= '0;
         sel_ff       <= SEL_HASH_A;
         cnt_ff       <= '0;
         result_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         sel_ff       <= sel_in;
         cnt_ff       <= cnt_in;
         result_ff    <= result_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      present_ff <= present_in;
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      result_in    = result_ff;
      present_in   = present_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      cmd.op       = DP_NOP;
      cmd.word_sel = word_ff;
      cmd.hash_sel = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op  = DP_CAPTURE;
               sel_in  = SEL_HASH_A;
               word_in = '0;
               state_in = (req_op == OP_PROBE) ? ST_H_INIT : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.op   = DP_MEM_WRITE;
            state_in = ST_IDLE;
         end
         ST_H_INIT: begin
            cmd.op   = DP_HASH_INIT;
            word_in  = '0;
            state_in = ST_K1;
         end
         ST_K1: begin
            cmd.op   = DP_KMUL1;
            state_in = ST_K2;
         end
         ST_K2: begin
            cmd.op   = DP_KMUL2;
            state_in = ST_HMIX;
         end
         ST_HMIX: begin
            cmd.op = DP_HMIX;
            if (word_ff == WORD_SEL_W'(KEY_WORDS - 1)) begin
               state_in = ST_F1;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = ST_K1;
            end
         end
         ST_F1: begin
            cmd.op   = DP_FIN1;
            state_in = ST_F2;
         end
         ST_F2: begin
            cmd.op   = DP_FIN2;
            state_in = ST_F3;
         end
         ST_F3: begin
            cmd.op = DP_FIN3;
            if (sel_ff == SEL_HASH_A) begin
               sel_in   = SEL_HASH_B;
               state_in = ST_H_INIT;
            end else if (probes == '0) begin
               result_in = 1'b1;
               state_in  = ST_DONE;
            end else if (cfg.bit_count == '0) begin
               result_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               sel_in   = SEL_HASH_A;
               state_in = ST_D_LOAD;
            end
         end
         ST_D_LOAD: begin
            cmd.op   = DP_DIV_LOAD;
            cnt_in   = '0;
            state_in = ST_D_STEP;
         end
         ST_D_STEP: begin
            cmd.op = DP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(HASH_W - 1)) begin
               state_in = ST_D_SAVE;
            end
         end
         ST_D_SAVE: begin
            cmd.op = (sel_ff == SEL_HASH_A) ? DP_SAVE_RUN : DP_SAVE_STEP;
            if (sel_ff == SEL_HASH_A) begin
               sel_in   = SEL_HASH_B;
               state_in = ST_D_LOAD;
            end else begin
               cnt_in   = '0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            cmd.op   = DP_MEM_READ;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!status.bit_set) begin
               result_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               cmd.op = DP_ADVANCE;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff + 1'b1 == probes) begin
                  result_in = 1'b1;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               present_in   = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_present = present_ff;

endmodule

FILE: rtl/bloom_filter_probe_murmur3.sv
// ----------------------------------------------------------------------------
// bloom_filter_probe_murmur3
// Bloom filter membership engine over 160-bit keys with MurmurHash3 double
// hashing and a 1 MiB on-chip filter store.
// ----------------------------------------------------------------------------
// A write transaction (req_tuser = 0) stores one filter byte and returns
// nothing. A probe transaction (req_tuser = 1) returns one result: two
// MurmurHash3 x86_32 passes run through one shared 32x32 multiplier, then
// the two 32-step bit-serial remainders of the hashes by the filter bit
// count, then one registered read of the filter store per tested bit. The
// bits are tested up to and including the first clear one, at most
// probe_count of them (clamped to 32). With probe_count or the bit count at
// zero nothing is tested and the remainders are skipped. One item is worked
// on at a time; a new item is taken while a result still waits on the
// output, and a finished probe holds until the output register is free. The
// filter store has no reset and must be written before it is probed. The
// registers must be written only while the block is idle; the block itself
// does not enforce it.
// ----------------------------------------------------------------------------
module bloom_filter_probe_murmur3 (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // byte_address, byte_value, key_word0 .. key_word4, zero pad
   input  logic [bfpm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  logic                             req_tuser,
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // present, zero pad
   output logic [bfpm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bfpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bfpm_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          present;

   bfpm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bfpm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_op      (req_tuser),
      .cfg         (cfg),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_present (present),
      .cmd         (cmd),
      .status      (status)
   );

   bfpm_dpath u_dpath (
      .clock      (clock),
      .cmd        (cmd),
      .req_fields (req_tdata[REQ_FIELD_W-1:0]),
      .bit_count  (cfg.bit_count),
      .status     (status)
   );

   // pack the result
   assign rsp_tdata = {(RSP_DATA_W-1)'(0), present};

endmodule

FILE: tb/bfpm_probe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfpm_probe_checker
// Watches the request, result and register channels of the Bloom filter probe
// engine, keeps its own image of the filter store and the registers, predicts
// the present flag of every probe and compares it with the returned result.
// ----------------------------------------------------------------------------
module bfpm_probe_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // byte_address, byte_value, key_word0 .. key_word4, zero pad
   input  logic [bfpm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // present, zero pad
   input  logic [bfpm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [bfpm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bfpm_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                               mismatch_count,
   output int                               awaiting,
   output int                               probes_seen,
   output int                               hits_seen
);
   import bfpm_pkg::*;

   localparam int KEY_W = KEY_WORDS * HASH_W;

   // Mirror of the filter store and the two registers
   logic [BYTE_VAL_W-1:0] filter_image [FILTER_BYTES];
   logic [NB_W-1:0]       cfg_bits = NB_RESET;
   logic [PC_W-1:0]       cfg_probes = PC_RESET;

   // Present flags of probes still in flight, oldest first
   logic                  expected_present [$];
   int                    results_seen = 0;
   logic                  want;

   initial begin
      mismatch_count = 0;
      awaiting       = 0;
      probes_seen    = 0;
      hits_seen      = 0;
   end

   // MurmurHash3 x86_32 over the five key words, final length 20
   function automatic logic [HASH_W-1:0] murmur_key(input logic [KEY_W-1:0] key,
                                                    input logic [HASH_W-1:0] seed);
      logic [HASH_W-1:0] h;
      logic [HASH_W-1:0] k;
      int                w;
      h = seed;
      for (w = 0; w < KEY_WORDS; w++) begin
         k = key[HASH_W*w +: HASH_W] * MM_C1;
         k = {k[16:0], k[31:17]};
         k = k * MM_C2;
         h = h ^ k;
         h = {h[18:0], h[31:19]};
         h = h * 32'd5 + MM_ADD;
      end
      h = h ^ KEY_LEN;
      h = h ^ (h >> 16);
      h = h * MM_F1;
      h = h ^ (h >> 13);
      h = h * MM_F2;
      h = h ^ (h >> 16);
      return h;
   endfunction

   // Walk the double-hash sequence against the store image, stop at a clear bit
   function automatic logic predict_present(input logic [KEY_W-1:0] key);
      logic [63:0] run;
      logic [63:0] step;
      logic [63:0] idx;
      logic [63:0] nbits;
      int          n;
      int          i;
      logic        hit;
      run   = {32'b0, murmur_key(key, SEED_A)};
      step  = {32'b0, murmur_key(key, SEED_A ^ SEED_MIX)};
      nbits = {40'b0, cfg_bits};
      n     = (cfg_probes > MAX_PROBES) ? MAX_PROBES : int'(cfg_probes);
      hit   = 1'b1;
      for (i = 0; i < n && hit; i++) begin
         if (nbits == 64'd0) begin
            hit = 1'b0;
         end else begin
            idx = run % nbits;
            // bits past the end of the store read as clear
            if ((idx >> 3) >= FILTER_BYTES) hit = 1'b0;
            else if (!filter_image[idx[ADDR_W+2:3]][idx[2:0]]) hit = 1'b0;
         end
         run = run + step;
      end
      return hit;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Check results first, then update the registers and the store image
   always @(posedge clock) begin
      if (reset) begin
         expected_present.delete();
         cfg_bits   = NB_RESET;
         cfg_probes = PC_RESET;
         awaiting   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_present.size() == 0) begin
               report_mismatch($sformatf("result %0d (tdata %h) with no probe waiting",
                                         results_seen, rsp_tdata));
            end else begin
               want = expected_present.pop_front();
               if (rsp_tdata !== {{(RSP_DATA_W-1){1'b0}}, want})
                  report_mismatch($sformatf("result %0d: tdata %h, present should be %0b",
                                            results_seen, rsp_tdata, want));
               if (want) hits_seen++;
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_BIT_COUNT) cfg_bits = csr_data[NB_W-1:0];
            else cfg_probes = csr_data[PC_W-1:0];
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_WRITE) begin
               filter_image[req_tdata[OFS_ADDR +: BYTE_ADDR_W]] =
                  req_tdata[OFS_VALUE +: BYTE_VAL_W];
            end else begin
               expected_present.insert(expected_present.size(),
                                       predict_present(req_tdata[OFS_KEY +: KEY_W]));
               probes_seen++;
            end
         end
         awaiting = expected_present.size();
      end
   end

endmodule

FILE: tb/tb_bloom_filter_probe_murmur3.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_probe_murmur3
// Stimulus and verdict for the Bloom filter probe engine. Drives filter byte
// writes and key probes under changing bit and probe counts, with random gaps,
// result stalls and one long result hold-off; the checker beside the block
// predicts and compares every result. Before each prepared probe the bytes it
// may test are written, and the other probes test no unwritten store byte.
// ----------------------------------------------------------------------------
module tb_bloom_filter_probe_murmur3;
   import bfpm_pkg::*;

   localparam int KEY_W        = KEY_WORDS * HASH_W;
   localparam int RESET_CYCLES = 8;
   localparam int TOTAL_ITEMS  = 650;
   localparam int WRITE_DRAIN  = 8;
   localparam int END_DRAIN    = 250;
   localparam int HOLD_CYCLES  = 600;
   localparam int LIMIT_NS     = 40_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = OP_WRITE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_BIT_COUNT;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int  mismatch_count;
   int  awaiting;
   int  probes_seen;
   int  hits_seen;

   // Stimulus bookkeeping
   bit              byte_written [FILTER_BYTES];
   logic [NB_W-1:0] cur_bits = NB_RESET;
   logic [PC_W-1:0] cur_probes = PC_RESET;
   int              item_count = 0;
   int              write_count = 0;
   int              setting_count = 0;
   bit              calm = 1'b0;
   bit              pressure_go = 1'b0;
   bit              pressure_done = 1'b0;
   int              hold_left = 0;

   always #10 clock = ~clock;

   bloom_filter_probe_murmur3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   bfpm_probe_checker u_membership_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .awaiting       (awaiting),
      .probes_seen    (probes_seen),
      .hits_seen      (hits_seen)
   );

   // Result side: random stalls, one long hold-off, none while calm
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (pressure_go && !pressure_done) begin
         rsp_tready    <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         pressure_done <= 1'b1;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= 28);
      end
   end

   // Abort a hung run
   initial begin
      #(LIMIT_NS);
      $display("status: fail");
      $finish;
   end

   function automatic logic [KEY_W-1:0] rand_key();
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   // Store byte that the first tested bit of a key falls into
   function automatic logic [63:0] first_byte(input logic [KEY_W-1:0] key);
      logic [63:0] run;
      run = {32'b0, u_membership_check.murmur_key(key, SEED_A)};
      return (run % {40'b0, cur_bits}) >> 3;
   endfunction

   // Offer one transaction, at times with a random gap ahead of it, and hold until taken
   task automatic send_item(input logic op, input logic [BYTE_ADDR_W-1:0] addr,
                            input logic [BYTE_VAL_W-1:0] value,
                            input logic [KEY_W-1:0] key);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(99) < 28) gap = $urandom_range(1, 3);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-REQ_FIELD_W){1'b0}}, key, value, addr};
      do @(posedge clock); while (!req_tready);
      item_count++;
      if (op == OP_WRITE) begin
         byte_written[addr] = 1'b1;
         write_count++;
      end
   endtask

   // Write the bytes a probe may test (unwritten ones always) when prep is set, then probe
   task automatic probe_key(input logic [KEY_W-1:0] key, input bit prep);
      logic [63:0]            run;
      logic [63:0]            step;
      logic [63:0]            idx;
      logic [BYTE_ADDR_W-1:0] addr;
      logic [BYTE_VAL_W-1:0]  value;
      int                     n;
      int                     i;
      if (prep && cur_bits != 0) begin
         run  = {32'b0, u_membership_check.murmur_key(key, SEED_A)};
         step = {32'b0, u_membership_check.murmur_key(key, SEED_A ^ SEED_MIX)};
         n    = (cur_probes > MAX_PROBES) ? MAX_PROBES : int'(cur_probes);
         for (i = 0; i < n; i++) begin
            idx = run % {40'b0, cur_bits};
            // a bit past the store reads clear and ends the probe
            if ((idx >> 3) >= FILTER_BYTES) break;
            addr = idx[ADDR_W+2:3];
            if (!byte_written[addr] || $urandom_range(2) == 0) begin
               value = BYTE_VAL_W'($urandom);
               value[idx[2:0]] = ($urandom_range(7) != 0);
               send_item(OP_WRITE, addr, value, rand_key());
            end
            run = run + step;
         end
      end
      send_item(OP_PROBE, BYTE_ADDR_W'($urandom), BYTE_VAL_W'($urandom), key);
   endtask

   // Drain the block, then write both registers back to back
   task automatic set_config(input logic [NB_W-1:0] bits, input logic [PC_W-1:0] probes);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (WRITE_DRAIN) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_BIT_COUNT;
      csr_data  <= bits;
      do @(posedge clock); while (!csr_ready);
      csr_index <= REG_PROBE_COUNT;
      csr_data  <= {{(CSR_DATA_W-PC_W){1'b0}}, probes};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_bits   = bits;
      cur_probes = probes;
      setting_count++;
   endtask

   initial begin
      logic [KEY_W-1:0] key;
      logic [NB_W-1:0]  bits;
      logic [PC_W-1:0]  probes;
      int               phase_len;
      int               j;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes under the reset settings
      send_item(OP_WRITE, '0, 8'h00, '0);
      send_item(OP_WRITE, '1, 8'hff, '1);
      probe_key('0, 1'b1);
      probe_key('1, 1'b1);

      // Zero probe count: nothing tested, always present
      set_config(NB_RESET, 6'd0);
      probe_key(rand_key(), 1'b0);

      // Zero bit count: nothing tested, never present
      set_config(24'd0, 6'd5);
      probe_key(rand_key(), 1'b0);

      // One filter bit under a probe count of 32, set and then clear
      set_config(24'd1, 6'd32);
      send_item(OP_WRITE, '0, 8'hff, rand_key());
      probe_key(rand_key(), 1'b0);
      send_item(OP_WRITE, '0, 8'hfe, rand_key());
      probe_key(rand_key(), 1'b0);

      // Probe count past the maximum saturates
      set_config(24'd16, 6'd33);
      send_item(OP_WRITE, 20'd0, 8'hff, rand_key());
      send_item(OP_WRITE, 20'd1, 8'hff, rand_key());
      probe_key(rand_key(), 1'b0);

      // Full-width bit count: first bit past the end of the store, then inside it
      set_config(24'hffffff, 6'd63);
      do key = rand_key(); while (first_byte(key) < FILTER_BYTES);
      probe_key(key, 1'b0);
      do key = rand_key(); while (first_byte(key) >= FILTER_BYTES);
      probe_key(key, 1'b1);

      // Highest legal bit count
      set_config(NB_RESET, 6'd2);
      probe_key(rand_key(), 1'b1);

      // Random phases, each under its own settings
      while (item_count < TOTAL_ITEMS) begin
         case ($urandom_range(9))
            0:       bits = 24'd1;
            1, 2:    bits = NB_W'($urandom_range(2, 64));
            3, 4:    bits = NB_W'($urandom_range(65, 4096));
            5:       bits = NB_RESET;
            6:       bits = NB_W'($urandom_range(8388609, 16777215));
            7:       bits = 24'hffffff;
            8:       bits = NB_W'($urandom_range(1, 8388608));
            default: bits = 24'd0;
         endcase
         case ($urandom_range(7))
            0:             probes = 6'd0;
            1, 2, 3, 4:    probes = PC_W'($urandom_range(1, 4));
            5:             probes = PC_W'($urandom_range(5, 32));
            6:             probes = 6'd32;
            default:       probes = PC_W'($urandom_range(33, 63));
         endcase
         set_config(bits, probes);
         phase_len = $urandom_range(30, 90);
         for (j = 0; j < phase_len && item_count < TOTAL_ITEMS; j++) begin
            calm = (item_count >= 250 && item_count < 330);
            if (item_count >= 120) pressure_go = 1'b1;
            // mostly prepared probes, some stray writes
            if ($urandom_range(99) < 80) probe_key(rand_key(), 1'b1);
            else send_item(OP_WRITE, BYTE_ADDR_W'($urandom), BYTE_VAL_W'($urandom),
                           rand_key());
         end
      end
      calm = 1'b0;

      // Wait out every result, then the block's latency
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (END_DRAIN) @(posedge clock);

      $display("covered %0d byte writes and %0d probes (%0d present) under %0d settings",
               write_count, probes_seen, hits_seen, setting_count);
      $display("bit counts from zero to full width, probe counts from zero past saturation");
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
